[rtl/kdpc_pkg.sv]
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared types and constants of the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdpc_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned HOLD_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 2'd2;

	localparam logic [CNT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd3;
	localparam logic [HOLD_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;
	localparam logic [HOLD_W-1:0] SCAN_PERIOD_RST = 16'd10;
	localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

	typedef struct packed {
		logic [CNT_W-1:0]  debounce_limit;
		logic [HOLD_W-1:0] long_press_time;
		logic [HOLD_W-1:0] scan_period;
	} cfg_t;

	typedef struct packed {
		logic stable_level;
		logic long_press;
		logic short_press;
	} res_t;

endpackage

[rtl/kdpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// kdpc_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module kdpc_cfg_regs
	import kdpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_limit  <= DEBOUNCE_LIMIT_RST;
			cfg_q.long_press_time <= LONG_PRESS_TIME_RST;
			cfg_q.scan_period     <= SCAN_PERIOD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEBOUNCE_LIMIT:  cfg_q.debounce_limit  <= wr_data[CNT_W-1:0];
				REG_LONG_PRESS_TIME: cfg_q.long_press_time <= wr_data[HOLD_W-1:0];
				REG_SCAN_PERIOD:     cfg_q.scan_period     <= wr_data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/kdpc_core.sv]
// ----------------------------------------------------------------------------
// kdpc_core
// Debounce and press classification state, updated once per processed scan.
// ----------------------------------------------------------------------------
module kdpc_core
	import kdpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic key_level,
	input  cfg_t cfg,
	output res_t res
);

	logic              prev_q;
	logic [CNT_W-1:0]  count_q;
	logic              stable_q;
	logic [HOLD_W-1:0] hold_q;
	logic              fired_q;

	logic              prev_d;
	logic [CNT_W-1:0]  count_d;
	logic              stable_d;
	logic [HOLD_W-1:0] hold_d;
	logic              fired_d;
	logic [HOLD_W:0]   grown;
	logic [HOLD_W-1:0] grown_sat;
	logic              short_p;
	logic              long_p;

	always_comb begin
		prev_d    = prev_q;
		count_d   = count_q;
		stable_d  = stable_q;
		hold_d    = hold_q;
		fired_d   = fired_q;
		short_p   = 1'b0;
		long_p    = 1'b0;
		grown     = {1'b0, hold_q} + {1'b0, cfg.scan_period};
		grown_sat = grown[HOLD_W] ? HOLD_MAX : grown[HOLD_W-1:0];
		if (key_level != prev_q) begin
			count_d = '0;
			prev_d  = key_level;
		end else if (count_q < cfg.debounce_limit) begin
			count_d = count_q + 1'b1;
		end else if (stable_q != key_level) begin
			stable_d = key_level;
			if (key_level) begin
				hold_d  = '0;
				fired_d = 1'b0;
			end else if (!fired_q) begin
				short_p = 1'b1;
			end
		end else if (stable_q && (hold_q < cfg.long_press_time)) begin
			hold_d = grown_sat;
			if ((grown_sat >= cfg.long_press_time) && !fired_q) begin
				fired_d = 1'b1;
				long_p  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			count_q  <= '0;
			stable_q <= 1'b0;
			hold_q   <= '0;
			fired_q  <= 1'b0;
		end else if (step) begin
			prev_q   <= prev_d;
			count_q  <= count_d;
			stable_q <= stable_d;
			hold_q   <= hold_d;
			fired_q  <= fired_d;
		end
	end

	assign res.short_press  = short_p;
	assign res.long_press   = long_p;
	assign res.stable_level = stable_d;

	a_pulses_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.short_press |-> !res.long_press)
		else $error("short and long press fired together");

	a_short_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.short_press |-> stable_q && !res.stable_level)
		else $error("short press without a debounced release");

	a_long_marks_fired: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.long_press |=> fired_q && stable_q)
		else $error("long press did not set the fired flag");

	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		step && fired_q && stable_q |-> !res.long_press)
		else $error("second long press in one hold");

endmodule

[rtl/key_debounce_press_classifier.sv]
// ----------------------------------------------------------------------------
// key_debounce_press_classifier
// Key debounce with short and long press detection, one scan per beat.
// ----------------------------------------------------------------------------
// A taken input beat waits in the input register, and its result is offered from the result register.
// Throughput: one beat per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset: arst_n clears all debounce state and both stage valids, and loads
// the register defaults (limit 3, long press time 1000, scan period 10).
module key_debounce_press_classifier
	import kdpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] key_level
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [0] short_press, [1] long_press, [2] stable_level
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;
	logic valid_s1;
	logic key_s1;
	logic valid_s2;
	res_t res_s2;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;

	kdpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kdpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.key_level (key_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1 <= s_tdata[0];
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.stable_level, res_s2.long_press, res_s2.short_press};

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key debounce and press classifier. A short
// scripted sequence walks the reset and corner settings of the timing
// registers, then several phases of random settings and one fixed setting
// drive well-formed press and release runs mixed with contact bounce. Both
// stream sides idle and stall at random. Each result beat is checked field
// by field against the script or a cycle-free bench model of the logic.
// ----------------------------------------------------------------------------
module tb_top;
	import kdpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 3000;

	typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  level;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] value;
		res_t                  want;
	} script_row_t;

	typedef struct packed {
		logic              prev_level;
		logic [CNT_W-1:0]  bounce_cnt;
		logic              stable;
		logic [HOLD_W-1:0] hold;
		logic              long_done;
	} key_track_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [0] key_level
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;   // [0] short_press, [1] long_press, [2] stable_level
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t       timing_cfg;
	key_track_t key_state;
	res_t       classified_due[$];
	int         fails;
	bit         calm;

	// The pulse field order is {stable_level, long_press, short_press}.
	script_row_t press_script [0:33] = '{
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b001},
		'{ROW_WRITE, 1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_WRITE, 1'b0, REG_LONG_PRESS_TIME, 16'hFFFF,  3'b000},
		'{ROW_WRITE, 1'b0, REG_SCAN_PERIOD,     16'hFFFF,  3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b110},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_WRITE, 1'b0, REG_LONG_PRESS_TIME, 16'd0,     3'b000},
		'{ROW_WRITE, 1'b0, REG_SCAN_PERIOD,     16'd1,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b001},
		'{ROW_WRITE, 1'b0, REG_SCAN_PERIOD,     16'd0,     3'b000},
		'{ROW_WRITE, 1'b0, REG_LONG_PRESS_TIME, 16'd1,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b000},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b1, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b100},
		'{ROW_SCAN,  1'b0, REG_DEBOUNCE_LIMIT,  16'd0,     3'b001}
	};

	key_debounce_press_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic res_t classify_scan(input logic level);
		res_t              r;
		logic [HOLD_W:0]   grown;
		r = '0;
		if (level != key_state.prev_level) begin
			key_state.bounce_cnt = '0;
			key_state.prev_level = level;
		end else if (key_state.bounce_cnt < timing_cfg.debounce_limit) begin
			key_state.bounce_cnt = key_state.bounce_cnt + 1'b1;
		end else if (key_state.stable != level) begin
			key_state.stable = level;
			if (level) begin
				key_state.hold = '0;
				key_state.long_done = 1'b0;
			end else if (!key_state.long_done) begin
				r.short_press = 1'b1;
			end
		end else if (key_state.stable) begin
			if (key_state.hold < timing_cfg.long_press_time) begin
				grown = {1'b0, key_state.hold} + {1'b0, timing_cfg.scan_period};
				if (grown > {1'b0, HOLD_MAX})
					grown = {1'b0, HOLD_MAX};
				key_state.hold = grown[HOLD_W-1:0];
				if (key_state.hold >= timing_cfg.long_press_time && !key_state.long_done) begin
					key_state.long_done = 1'b1;
					r.long_press = 1'b1;
				end
			end
		end
		r.stable_level = key_state.stable;
		return r;
	endfunction

	function automatic int unsigned pick_idle();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_scan(input logic level, input bit typed, input res_t want);
		int unsigned gap;
		res_t        predicted;
		gap = pick_idle();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, level};
		do @(negedge clk); while (!s_tready);
		predicted = classify_scan(level);
		classified_due.push_back(typed ? want : predicted);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		s_tvalid <= 1'b0;
		while (classified_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE_LIMIT:  timing_cfg.debounce_limit = value[CNT_W-1:0];
			REG_LONG_PRESS_TIME: timing_cfg.long_press_time = value;
			REG_SCAN_PERIOD:     timing_cfg.scan_period = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_timing();
		int unsigned          sel;
		logic [CNT_W-1:0]     lim;
		logic [HOLD_W-1:0]    lpt;
		logic [HOLD_W-1:0]    per;
		sel = $urandom_range(0, 7);
		lim = CNT_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 20));
		case (sel)
			0: begin
				lpt = '0;
				per = HOLD_W'($urandom_range(1, 65535));
			end
			1: begin
				lpt = HOLD_MAX;
				per = HOLD_W'($urandom_range(20000, 65535));
			end
			2: begin
				lpt = HOLD_W'($urandom_range(0, 65535));
				per = HOLD_MAX;
			end
			3: begin
				lpt = HOLD_W'($urandom_range(1, 80));
				per = '0;
			end
			default: begin
				lpt = HOLD_W'($urandom_range(1, 80));
				per = HOLD_W'($urandom_range(1, 20));
			end
		endcase
		write_reg(REG_DEBOUNCE_LIMIT, {8'd0, lim});
		write_reg(REG_LONG_PRESS_TIME, lpt);
		write_reg(REG_SCAN_PERIOD, per);
	endtask

	// Most runs are long enough to settle, presses often long enough to fire;
	// the rest are bounces too short to move the debounced state.
	task automatic run_presses(input int unsigned budget);
		int unsigned sent;
		int unsigned span;
		int unsigned run_len;
		int unsigned lim;
		logic        lvl;
		sent = 0;
		while (sent < budget) begin
			lvl = ~key_state.prev_level;
			lim = timing_cfg.debounce_limit;
			if ($urandom_range(0, 9) >= 7) begin
				run_len = $urandom_range(1, (lim < 11) ? lim + 1 : 12);
			end else if (lvl) begin
				if (timing_cfg.scan_period == '0)
					span = 8;
				else
					span = timing_cfg.long_press_time / timing_cfg.scan_period + 3;
				if (span > 90)
					span = 90;
				run_len = lim + 2 + $urandom_range(0, span);
			end else begin
				run_len = lim + 2 + $urandom_range(0, 4);
			end
			repeat (run_len) send_scan(lvl, 1'b0, '0);
			sent += run_len;
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DEBOUNCE_LIMIT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		fails = 0;
		calm = 1'b0;
		timing_cfg = '{DEBOUNCE_LIMIT_RST, LONG_PRESS_TIME_RST, SCAN_PERIOD_RST};
		key_state = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (press_script[i]) begin
			if (press_script[i].kind == ROW_WRITE)
				write_reg(press_script[i].reg_idx, press_script[i].value);
			else
				send_scan(press_script[i].level, 1'b1, press_script[i].want);
		end
		for (int phase = 0; phase < 5; phase++) begin
			calm = (phase == 2);
			pick_timing();
			run_presses(40);
		end
		calm = 1'b0;
		write_reg(REG_DEBOUNCE_LIMIT, 16'd255);
		write_reg(REG_LONG_PRESS_TIME, 16'd20);
		write_reg(REG_SCAN_PERIOD, 16'd7);
		run_presses(200);
		s_tvalid <= 1'b0;
		while (classified_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			stall = pick_idle();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(negedge clk) begin : result_check
		res_t want;
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[2:0];
			if (classified_due.size() == 0) begin
				$error("result beat with nothing expected: m_tdata=%b", m_tdata);
				fails++;
			end else begin
				want = classified_due.pop_front();
				if (got.short_press !== want.short_press) begin
					$error("short_press expected %b actual %b", want.short_press, got.short_press);
					fails++;
				end
				if (got.long_press !== want.long_press) begin
					$error("long_press expected %b actual %b", want.long_press, got.long_press);
					fails++;
				end
				if (got.stable_level !== want.stable_level) begin
					$error("stable_level expected %b actual %b", want.stable_level,
						got.stable_level);
					fails++;
				end
			end
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule
